// File: design/bbc_pkg.sv
// Shared types and constants of the byte bigram counter.
// Used by every module of the block except bbc_ram; depends on nothing.

package bbc_pkg;

   localparam int SYMBOL_BITS        = 8;
   localparam int SLOT_BITS          = 8;
   localparam int USED_BITS          = 9;
   localparam int TOTAL_BITS         = 32;
   localparam int COUNT_BITS_DEFAULT = 32;

   localparam int MASK_WORDS         = 4;
   localparam int MASK_WORD_BITS     = 64;
   localparam int CSR_INDEX_BITS     = 2;
   localparam int CSR_DATA_BITS      = MASK_WORD_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IGNORE_MASK_0 = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IGNORE_MASK_1 = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IGNORE_MASK_2 = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IGNORE_MASK_3 = 2'd3;

   // Decoded byte as it leaves the front end.
   typedef struct packed {
      logic [SYMBOL_BITS-1:0] key;
      logic [SYMBOL_BITS-1:0] sym;
      logic                   counted;
      logic                   key_new;
      logic [SLOT_BITS-1:0]   new_key_slot;
   } bbc_item_type;

   typedef struct packed {
      logic                   pair_counted;
      logic [SYMBOL_BITS-1:0] from_symbol;
      logic [SYMBOL_BITS-1:0] to_symbol;
      logic [SLOT_BITS-1:0]   key_slot;
      logic [SLOT_BITS-1:0]   follower_slot;
      logic                   key_is_new;
      logic                   pair_is_new;
      logic [TOTAL_BITS-1:0]  pair_total;
      logic [TOTAL_BITS-1:0]  key_total;
   } bbc_result_type;

endpackage

// File: design/bbc_req_if.sv
// Input channel of the byte bigram counter: one stream byte per word.
// Depends on bbc_pkg for the field widths.

interface bbc_req_if;
   logic                            valid;
   logic                            ready;
   logic [bbc_pkg::SYMBOL_BITS-1:0] symbol;
   logic                            stream_start;

   modport source (output valid, output symbol, output stream_start, input ready);
   modport sink (input valid, input symbol, input stream_start, output ready);
endinterface

// File: design/bbc_rsp_if.sv
// Result channel of the byte bigram counter: one result word per input byte.
// Depends on bbc_pkg for the field widths.

interface bbc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            pair_counted;
   logic [bbc_pkg::SYMBOL_BITS-1:0] from_symbol;
   logic [bbc_pkg::SYMBOL_BITS-1:0] to_symbol;
   logic [bbc_pkg::SLOT_BITS-1:0]   key_slot;
   logic [bbc_pkg::SLOT_BITS-1:0]   follower_slot;
   logic                            key_is_new;
   logic                            pair_is_new;
   logic [bbc_pkg::TOTAL_BITS-1:0]  pair_total;
   logic [bbc_pkg::TOTAL_BITS-1:0]  key_total;

   modport source (output valid, output pair_counted, output from_symbol, output to_symbol,
                   output key_slot, output follower_slot, output key_is_new,
                   output pair_is_new, output pair_total, output key_total, input ready);
   modport sink (input valid, input pair_counted, input from_symbol, input to_symbol,
                 input key_slot, input follower_slot, input key_is_new,
                 input pair_is_new, input pair_total, input key_total, output ready);
endinterface

// File: design/bbc_ram.sv
// Generic simple dual-port RAM with a registered read (read-first on collision).
// Stand-alone; depends on nothing.

module bbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH] = '{default: '0};

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

endmodule

// File: design/bbc_front.sv
// Front end: ignore mask registers, preceding byte, key valid bits and key slot allocation.
// Depends on bbc_pkg.

module bbc_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bbc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [bbc_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                                accept,
   input  logic [bbc_pkg::SYMBOL_BITS-1:0]     symbol,
   input  logic                                stream_start,
   output bbc_pkg::bbc_item_type               item
);

   localparam int KEY_DEPTH = 2 ** bbc_pkg::SYMBOL_BITS;

   logic [bbc_pkg::MASK_WORDS-1:0][bbc_pkg::MASK_WORD_BITS-1:0] mask_ff;
   logic [bbc_pkg::SYMBOL_BITS-1:0] prev_symbol_ff;
   logic                            prev_valid_ff;
   logic [KEY_DEPTH-1:0]            key_valid_ff;
   logic [bbc_pkg::USED_BITS-1:0]   keys_used_ff;

   logic [KEY_DEPTH-1:0] mask_flat;

   // The packed mask flattens so that bit v belongs to byte value v.
   assign mask_flat = mask_ff;

   always_comb begin
      item.key          = prev_symbol_ff;
      item.sym          = symbol;
      item.counted      = !stream_start && prev_valid_ff &&
                          !mask_flat[symbol] && !mask_flat[prev_symbol_ff];
      item.key_new      = item.counted && !key_valid_ff[prev_symbol_ff];
      item.new_key_slot = keys_used_ff[bbc_pkg::SLOT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            bbc_pkg::CSR_IGNORE_MASK_0: mask_ff[0] <= csr_wdata;
            bbc_pkg::CSR_IGNORE_MASK_1: mask_ff[1] <= csr_wdata;
            bbc_pkg::CSR_IGNORE_MASK_2: mask_ff[2] <= csr_wdata;
            bbc_pkg::CSR_IGNORE_MASK_3: mask_ff[3] <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_symbol_ff <= '0;
         prev_valid_ff  <= 1'b0;
         key_valid_ff   <= '0;
         keys_used_ff   <= '0;
      end else if (accept) begin
         prev_symbol_ff <= symbol;
         prev_valid_ff  <= 1'b1;
         if (stream_start) begin
            key_valid_ff <= '0;
            keys_used_ff <= '0;
         end else if (item.key_new) begin
            key_valid_ff[prev_symbol_ff] <= 1'b1;
            keys_used_ff <= keys_used_ff + bbc_pkg::USED_BITS'(1);
         end
      end
   end

endmodule

// File: design/bbc_update.sv
// Read-modify-write pipeline over the key, pair and follower-index memories.
// Depends on bbc_pkg and bbc_ram.

module bbc_update #(
   parameter int COUNT_BITS = bbc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_valid,
   input  bbc_pkg::bbc_item_type   in_item,
   output logic                    out_valid,
   output bbc_pkg::bbc_result_type out_result
);

   localparam int SYM        = bbc_pkg::SYMBOL_BITS;
   localparam int SLOT       = bbc_pkg::SLOT_BITS;
   localparam int USED       = bbc_pkg::USED_BITS;
   localparam int TOTAL      = bbc_pkg::TOTAL_BITS;
   localparam int KEY_DEPTH  = 2 ** SYM;
   localparam int PAIR_DEPTH = 2 ** (2 * SYM);
   localparam int INV_DEPTH  = 2 ** (SYM + SLOT);
   localparam int KEY_WIDTH  = SLOT + USED + COUNT_BITS;
   localparam int PAIR_WIDTH = SLOT + COUNT_BITS;

   typedef struct packed {
      logic [SLOT-1:0]       slot;
      logic [USED-1:0]       used;
      logic [COUNT_BITS-1:0] total;
   } key_rec_type;

   typedef struct packed {
      logic [SLOT-1:0]       slot;
      logic [COUNT_BITS-1:0] count;
   } pair_rec_type;

   logic [KEY_WIDTH-1:0]  key_rdata;
   logic [PAIR_WIDTH-1:0] pair_rdata;
   logic [SYM-1:0]        inv_rdata;

   logic                  s1_valid_ff;
   bbc_pkg::bbc_item_type s1_item_ff;
   key_rec_type           s1_key;
   pair_rec_type          s1_pair;

   logic                  s2_valid_ff;
   bbc_pkg::bbc_item_type s2_item_ff;
   key_rec_type           s2_key_ff;
   pair_rec_type          s2_pair_ff;
   logic                  s2_write;
   logic                  s2_hit;
   logic [SYM-1:0]        s2_inv;
   key_rec_type           s2_key_wr;
   pair_rec_type          s2_pair_wr;

   logic                  w_key_valid_ff;
   logic [SYM-1:0]        w_key_addr_ff;
   key_rec_type           w_key_data_ff;
   logic                  w_pair_valid_ff;
   logic [2*SYM-1:0]      w_pair_addr_ff;
   pair_rec_type          w_pair_data_ff;
   logic                  w_inv_valid_ff;
   logic [SYM+SLOT-1:0]   w_inv_addr_ff;
   logic [SYM-1:0]        w_inv_data_ff;

   // Key record: slot, follower fill count and key total.
   bbc_ram #(.WIDTH(KEY_WIDTH), .DEPTH(KEY_DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (adv && s2_write),
      .wr_addr (s2_item_ff.key),
      .wr_data (s2_key_wr),
      .rd_en   (adv),
      .rd_addr (in_item.key),
      .rd_data (key_rdata)
   );

   // Pair record: follower slot and pair count, addressed by key and follower.
   bbc_ram #(.WIDTH(PAIR_WIDTH), .DEPTH(PAIR_DEPTH)) u_pair_ram (
      .clock   (clock),
      .wr_en   (adv && s2_write),
      .wr_addr ({s2_item_ff.key, s2_item_ff.sym}),
      .wr_data (s2_pair_wr),
      .rd_en   (adv),
      .rd_addr ({in_item.key, in_item.sym}),
      .rd_data (pair_rdata)
   );

   // Follower byte held by each allocated slot of a key. A pair record counts only if
   // its slot lies below the key's fill count and this table points back at it, so
   // neither pair memory needs clearing.
   bbc_ram #(.WIDTH(SYM), .DEPTH(INV_DEPTH)) u_inv_ram (
      .clock   (clock),
      .wr_en   (adv && s2_write && !s2_hit),
      .wr_addr ({s2_item_ff.key, s2_key_ff.used[SLOT-1:0]}),
      .wr_data (s2_item_ff.sym),
      .rd_en   (adv),
      .rd_addr ({s1_item_ff.key, s1_pair.slot}),
      .rd_data (inv_rdata)
   );

   // Stage 1: memory data arrives; newer writes still in flight take precedence.
   always_comb begin
      s1_key = key_rec_type'(key_rdata);
      if (s2_write && s2_item_ff.key == s1_item_ff.key) begin
         s1_key = s2_key_wr;
      end else if (w_key_valid_ff && w_key_addr_ff == s1_item_ff.key) begin
         s1_key = w_key_data_ff;
      end
      // A key first seen in this stream starts from its cleared record.
      if (s1_item_ff.key_new) begin
         s1_key.slot  = s1_item_ff.new_key_slot;
         s1_key.used  = '0;
         s1_key.total = '0;
      end
   end

   always_comb begin
      s1_pair = pair_rec_type'(pair_rdata);
      if (s2_write && {s2_item_ff.key, s2_item_ff.sym} == {s1_item_ff.key, s1_item_ff.sym}) begin
         s1_pair = s2_pair_wr;
      end else if (w_pair_valid_ff &&
                   w_pair_addr_ff == {s1_item_ff.key, s1_item_ff.sym}) begin
         s1_pair = w_pair_data_ff;
      end
   end

   // Stage 2: decide whether the pair is known, then build the write-back records.
   always_comb begin
      s2_write = s2_valid_ff && s2_item_ff.counted;
      s2_inv   = inv_rdata;
      if (w_inv_valid_ff && w_inv_addr_ff == {s2_item_ff.key, s2_pair_ff.slot}) begin
         s2_inv = w_inv_data_ff;
      end
      s2_hit = (USED'(s2_pair_ff.slot) < s2_key_ff.used) && (s2_inv == s2_item_ff.sym);

      s2_key_wr.slot  = s2_key_ff.slot;
      s2_key_wr.used  = s2_hit ? s2_key_ff.used : s2_key_ff.used + USED'(1);
      s2_key_wr.total = (s2_key_ff.total == '1) ? s2_key_ff.total
                                                 : s2_key_ff.total + COUNT_BITS'(1);
      if (s2_hit) begin
         s2_pair_wr.slot  = s2_pair_ff.slot;
         s2_pair_wr.count = (s2_pair_ff.count == '1) ? s2_pair_ff.count
                                                      : s2_pair_ff.count + COUNT_BITS'(1);
      end else begin
         s2_pair_wr.slot  = s2_key_ff.used[SLOT-1:0];
         s2_pair_wr.count = COUNT_BITS'(1);
      end
   end

   always_comb begin
      out_valid  = s2_valid_ff;
      out_result = '0;
      if (s2_item_ff.counted) begin
         out_result.pair_counted  = 1'b1;
         out_result.from_symbol   = s2_item_ff.key;
         out_result.to_symbol     = s2_item_ff.sym;
         out_result.key_slot      = s2_key_ff.slot;
         out_result.follower_slot = s2_pair_wr.slot;
         out_result.key_is_new    = s2_item_ff.key_new;
         out_result.pair_is_new   = !s2_hit;
         out_result.pair_total    = TOTAL'(s2_pair_wr.count);
         out_result.key_total     = TOTAL'(s2_key_wr.total);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         w_key_valid_ff  <= 1'b0;
         w_pair_valid_ff <= 1'b0;
         w_inv_valid_ff  <= 1'b0;
      end else if (adv) begin
         s1_valid_ff     <= in_valid;
         s2_valid_ff     <= s1_valid_ff;
         w_key_valid_ff  <= s2_write;
         w_pair_valid_ff <= s2_write;
         w_inv_valid_ff  <= s2_write && !s2_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_item_ff     <= in_item;
         s2_item_ff     <= s1_item_ff;
         s2_key_ff      <= s1_key;
         s2_pair_ff     <= s1_pair;
         w_key_addr_ff  <= s2_item_ff.key;
         w_key_data_ff  <= s2_key_wr;
         w_pair_addr_ff <= {s2_item_ff.key, s2_item_ff.sym};
         w_pair_data_ff <= s2_pair_wr;
         w_inv_addr_ff  <= {s2_item_ff.key, s2_key_ff.used[SLOT-1:0]};
         w_inv_data_ff  <= s2_item_ff.sym;
      end
   end

endmodule

// File: design/byte_bigram_counter_core.sv
// Top level of the byte bigram counter: front end, update pipeline and result register.
// Depends on bbc_pkg, bbc_req_if, bbc_rsp_if, bbc_front and bbc_update.
//
//   channel   direction  word                          handshake
//   req_port  in         symbol, stream_start          valid/ready
//   rsp_port  out        pair and key slots and counts valid/ready
//   csr_*     in         ignore mask words 0..3        write enable, no wait
//
// One byte is taken per cycle while the pipeline is not held; its result passes through the
// update pipeline registers into the output register. Each result comes from a read-modify-
// write over the key, pair and follower-index RAMs, with forwarding between back-to-back updates.
// Reset needs no clearing pass: key valid bits clear at once and pair records are checked
// against each key's fill count. A stream start clears the tables the same way.
// The pipeline holds only when its last stage is full and the output register is not taken.

module byte_bigram_counter_core #(
   parameter int COUNT_BITS = bbc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [bbc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bbc_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   bbc_req_if.sink                            req_port,
   bbc_rsp_if.source                          rsp_port
);

   bbc_pkg::bbc_item_type   item;
   bbc_pkg::bbc_result_type s2_result;
   logic                    s2_valid;
   logic                    adv;
   logic                    accept;
   logic                    load;

   logic                    out_valid_ff;
   logic                    out_valid_in;
   bbc_pkg::bbc_result_type out_data_ff;

   // The pipeline may move whenever its last stage has somewhere to go.
   assign adv    = !s2_valid || !out_valid_ff || rsp_port.ready;
   assign accept = req_port.valid && adv;
   assign load   = adv && s2_valid;
   assign req_port.ready = adv;

   bbc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .symbol       (req_port.symbol),
      .stream_start (req_port.stream_start),
      .item         (item)
   );

   bbc_update #(.COUNT_BITS(COUNT_BITS)) u_update (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (accept),
      .in_item    (item),
      .out_valid  (s2_valid),
      .out_result (s2_result)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_data_ff <= s2_result;
      end
   end

   assign rsp_port.valid         = out_valid_ff;
   assign rsp_port.pair_counted  = out_data_ff.pair_counted;
   assign rsp_port.from_symbol   = out_data_ff.from_symbol;
   assign rsp_port.to_symbol     = out_data_ff.to_symbol;
   assign rsp_port.key_slot      = out_data_ff.key_slot;
   assign rsp_port.follower_slot = out_data_ff.follower_slot;
   assign rsp_port.key_is_new    = out_data_ff.key_is_new;
   assign rsp_port.pair_is_new   = out_data_ff.pair_is_new;
   assign rsp_port.pair_total    = out_data_ff.pair_total;
   assign rsp_port.key_total     = out_data_ff.key_total;

endmodule

// File: design/bbc_checker.sv
// Port-level checks on the result channel of the byte bigram counter, with its bind.
// Depends on bbc_pkg and byte_bigram_counter_core.

module bbc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            pair_counted,
   input logic [bbc_pkg::SYMBOL_BITS-1:0] from_symbol,
   input logic [bbc_pkg::SYMBOL_BITS-1:0] to_symbol,
   input logic [bbc_pkg::SLOT_BITS-1:0]   key_slot,
   input logic [bbc_pkg::SLOT_BITS-1:0]   follower_slot,
   input logic                            key_is_new,
   input logic                            pair_is_new,
   input logic [bbc_pkg::TOTAL_BITS-1:0]  pair_total,
   input logic [bbc_pkg::TOTAL_BITS-1:0]  key_total
);

   // A word that waits keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pair_total) && $stable(key_total) &&
                                  $stable(from_symbol) && $stable(to_symbol))
      else $error("result word changed while stalled");

   // A byte that formed no pair reports nothing else.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !pair_counted |-> from_symbol == '0 && to_symbol == '0 &&
         key_slot == '0 && follower_slot == '0 && !key_is_new && !pair_is_new &&
         pair_total == '0 && key_total == '0)
      else $error("uncounted byte carries nonzero fields");

   // A key seen for the first time cannot have a known follower.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && key_is_new |-> pair_is_new && pair_counted)
      else $error("new key reported with a known pair");

   // A new pair starts its count at one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pair_is_new |-> pair_total == bbc_pkg::TOTAL_BITS'(1))
      else $error("new pair with a count other than one");

endmodule

bind byte_bigram_counter_core bbc_checker u_bbc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_port.valid),
   .rsp_ready     (rsp_port.ready),
   .pair_counted  (rsp_port.pair_counted),
   .from_symbol   (rsp_port.from_symbol),
   .to_symbol     (rsp_port.to_symbol),
   .key_slot      (rsp_port.key_slot),
   .follower_slot (rsp_port.follower_slot),
   .key_is_new    (rsp_port.key_is_new),
   .pair_is_new   (rsp_port.pair_is_new),
   .pair_total    (rsp_port.pair_total),
   .key_total     (rsp_port.key_total)
);
